@@ rtl/core/qppm_pkg.sv @@
package qppm_pkg;

  // field widths
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int H_BITS     = 32;
  localparam int CFG_W      = 64;
  localparam int IDX_W      = 3;
  localparam int OUT_W      = 16;
  localparam int AREA_TOL   = 5;

  // derived arithmetic widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int TRI_W   = CROSS_W - 1;
  localparam int AQ_W    = TRI_W + 1;
  localparam int AP_W    = TRI_W + 2;
  localparam int PROD_W  = H_BITS + COORD_BITS + 1;
  localparam int NUM_W   = PROD_W + 2;
  localparam int MAG_W   = NUM_W;
  localparam int QBITS   = OUT_W + 1;
  localparam int DIV_W   = MAG_W + QBITS;
  localparam int CORNER_PAIR_W = 4 * COORD_BITS;

  localparam logic signed [NUM_W-1:0] ONE_FX = NUM_W'(1) << FRAC_BITS;
  localparam logic [QBITS-1:0] MAX_POS = QBITS'(32767);
  localparam logic [QBITS-1:0] MAX_NEG = QBITS'(32768);
  localparam logic signed [OUT_W-1:0] SAT_HI = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] SAT_LO = 16'sh8000;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_COEF_A    = 3'd0,
    REG_COEF_B    = 3'd1,
    REG_COEF_C    = 3'd2,
    REG_COEF_D    = 3'd3,
    REG_CORNERS_F = 3'd4,
    REG_CORNERS_B = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] s;
    logic [COORD_BITS-1:0] f;
  } pt_t;

  typedef pt_t [3:0] corners_t;
  typedef logic [7:0][H_BITS-1:0] coef_t;

  // control travelling with each item
  typedef struct packed {
    logic valid;
    logic in_quad;
    logic den_ok;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [MAG_W-1:0] nf_mag;
    logic [MAG_W-1:0] ns_mag;
    logic [MAG_W-1:0] den_mag;
    logic             nf_neg;
    logic             ns_neg;
    logic             nf_ovf;
    logic             ns_ovf;
  } front_t;

  typedef struct packed {
    tag_t             tag;
    logic [QBITS-1:0] qf;
    logic [QBITS-1:0] qs;
    logic             nf_neg;
    logic             ns_neg;
    logic             nf_ovf;
    logic             ns_ovf;
  } div_out_t;

  // signed quotient from magnitude, clamped to the output range
  function automatic logic signed [OUT_W-1:0] sat_q(input logic [QBITS-1:0] q,
                                                    input logic neg, input logic ovf);
    logic [QBITS-1:0] nq;
    logic signed [OUT_W-1:0] r;
    nq = -q;
    if (!neg) begin
      r = (ovf || q > MAX_POS) ? SAT_HI : $signed(q[OUT_W-1:0]);
    end else begin
      r = (ovf || q > MAX_NEG) ? SAT_LO : $signed(nq[OUT_W-1:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/qppm_front.sv @@
module qppm_front import qppm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [COORD_BITS-1:0] u,
  input  logic [COORD_BITS-1:0] v,
  input  coef_t                 coef,
  input  corners_t              corners,
  output front_t                fo
);

  function automatic logic [TRI_W-1:0] tri_of(input logic signed [CROSS_W-1:0] x);
    logic [CROSS_W-1:0] m;
    m = x[CROSS_W-1] ? -x : x;
    return m[CROSS_W-1:1];
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [NUM_W-1:0] x);
    return x[NUM_W-1] ? MAG_W'(-x) : MAG_W'(x);
  endfunction

  // stage 1 registers
  logic                     v1, inbox1;
  logic signed [DIFF_W-1:0] df1 [4];
  logic signed [DIFF_W-1:0] ds1 [4];
  logic signed [PROD_W-1:0] prod1 [6];
  // stage 2 registers
  logic                      v2, inbox2;
  logic signed [CROSS_W-1:0] cross2 [4];
  logic signed [NUM_W-1:0]   nf2, ns2, den2;
  // stage 3 registers
  logic             v3, inbox3, dok3, nfneg3, nsneg3;
  logic [AP_W-1:0]  ap3;
  logic [MAG_W-1:0] nfm3, nsm3, dm3;
  // quad area, follows the corner registers
  logic [AQ_W-1:0]  aq;

  // stage 1 combinational: bounding box, corner offsets, products
  logic [COORD_BITS-1:0]    minf, maxf, mins, maxs;
  logic                     inbox_n;
  logic signed [DIFF_W-1:0] df_n [4];
  logic signed [DIFF_W-1:0] ds_n [4];
  logic signed [PROD_W-1:0] prod_n [6];
  logic signed [DIFF_W-1:0] ue, ve;

  always_comb begin
    ue = $signed({1'b0, u});
    ve = $signed({1'b0, v});
    minf = corners[0].f;
    maxf = corners[0].f;
    mins = corners[0].s;
    maxs = corners[0].s;
    for (int k = 1; k < 4; k++) begin
      if (corners[k].f < minf) minf = corners[k].f;
      if (corners[k].f > maxf) maxf = corners[k].f;
      if (corners[k].s < mins) mins = corners[k].s;
      if (corners[k].s > maxs) maxs = corners[k].s;
    end
    inbox_n = (u >= minf) && (u < maxf) && (v >= mins) && (v < maxs);
    for (int k = 0; k < 4; k++) begin
      df_n[k] = $signed({1'b0, corners[k].f}) - ue;
      ds_n[k] = $signed({1'b0, corners[k].s}) - ve;
    end
    prod_n[0] = $signed(coef[0]) * ue;
    prod_n[1] = $signed(coef[1]) * ve;
    prod_n[2] = $signed(coef[3]) * ue;
    prod_n[3] = $signed(coef[4]) * ve;
    prod_n[4] = $signed(coef[6]) * ue;
    prod_n[5] = $signed(coef[7]) * ve;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inbox1 <= inbox_n;
      df1    <= df_n;
      ds1    <= ds_n;
      prod1  <= prod_n;
    end
  end

  // stage 2: cross products and projective sums
  logic signed [CROSS_W-1:0] cross_n [4];
  logic signed [NUM_W-1:0]   nf_n, ns_n, den_n;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cross_n[k] = df1[k] * ds1[(k + 1) % 4] - ds1[k] * df1[(k + 1) % 4];
    end
    nf_n  = prod1[0] + prod1[1] + $signed(coef[2]);
    ns_n  = prod1[2] + prod1[3] + $signed(coef[5]);
    den_n = prod1[4] + prod1[5] + ONE_FX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inbox2 <= inbox1;
      cross2 <= cross_n;
      nf2    <= nf_n;
      ns2    <= ns_n;
      den2   <= den_n;
    end
  end

  // stage 3: pixel area sum and magnitudes for the divider
  logic [AP_W-1:0] ap_n;

  always_comb begin
    ap_n = '0;
    for (int k = 0; k < 4; k++) begin
      ap_n = ap_n + AP_W'(tri_of(cross2[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inbox3 <= inbox2;
      ap3    <= ap_n;
      nfm3   <= mag_of(nf2);
      nsm3   <= mag_of(ns2);
      dm3    <= mag_of(den2);
      nfneg3 <= nf2[NUM_W-1] ^ den2[NUM_W-1];
      nsneg3 <= ns2[NUM_W-1] ^ den2[NUM_W-1];
      dok3   <= (den2 != '0);
    end
  end

  // quad area from two triangles, tracks the corner registers
  logic signed [DIFF_W-1:0]  e1f, e1s, e3f, e3s, g1f, g1s, g3f, g3s;
  logic signed [CROSS_W-1:0] qa_x, qb_x;

  always_comb begin
    e1f = $signed({1'b0, corners[1].f}) - $signed({1'b0, corners[0].f});
    e1s = $signed({1'b0, corners[1].s}) - $signed({1'b0, corners[0].s});
    e3f = $signed({1'b0, corners[3].f}) - $signed({1'b0, corners[0].f});
    e3s = $signed({1'b0, corners[3].s}) - $signed({1'b0, corners[0].s});
    g1f = $signed({1'b0, corners[1].f}) - $signed({1'b0, corners[2].f});
    g1s = $signed({1'b0, corners[1].s}) - $signed({1'b0, corners[2].s});
    g3f = $signed({1'b0, corners[3].f}) - $signed({1'b0, corners[2].f});
    g3s = $signed({1'b0, corners[3].s}) - $signed({1'b0, corners[2].s});
    qa_x = e1f * e3s - e1s * e3f;
    qb_x = g1f * g3s - g1s * g3f;
  end

  always_ff @(posedge clk) begin
    aq <= AQ_W'(tri_of(qa_x)) + AQ_W'(tri_of(qb_x));
  end

  // stage 4: area tolerance and quotient overflow check
  logic signed [AP_W:0] adiff;
  logic [DIV_W-1:0]     dsh;

  always_comb begin
    adiff = $signed({2'b00, aq}) - $signed({1'b0, ap3});
    dsh   = {dm3, QBITS'(0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fo.tag.valid <= 1'b0;
    end else if (en) begin
      fo.tag.valid <= v3;
    end
    if (en) begin
      fo.tag.in_quad <= inbox3 && (adiff < $signed((AP_W+1)'(AREA_TOL)))
                        && (adiff > -$signed((AP_W+1)'(AREA_TOL)));
      fo.tag.den_ok  <= dok3;
      fo.nf_mag      <= nfm3;
      fo.ns_mag      <= nsm3;
      fo.den_mag     <= dm3;
      fo.nf_neg      <= nfneg3;
      fo.ns_neg      <= nsneg3;
      fo.nf_ovf      <= {QBITS'(0), nfm3} >= dsh;
      fo.ns_ovf      <= {QBITS'(0), nsm3} >= dsh;
    end
  end

endmodule

@@ rtl/core/qppm_div.sv @@
module qppm_div import qppm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  front_t   di,
  output div_out_t dq
);

  typedef struct packed {
    tag_t             tag;
    logic [MAG_W-1:0] rf;
    logic [MAG_W-1:0] rs;
    logic [MAG_W-1:0] dm;
    logic [QBITS-1:0] qf;
    logic [QBITS-1:0] qs;
    logic             nf_neg;
    logic             ns_neg;
    logic             nf_ovf;
    logic             ns_ovf;
  } div_st_t;

  div_st_t st  [QBITS];
  div_st_t nxt [QBITS];
  div_st_t init;

  // first stage takes the magnitudes as partial remainders
  always_comb begin
    init.tag    = di.tag;
    init.rf     = di.nf_mag;
    init.rs     = di.ns_mag;
    init.dm     = di.den_mag;
    init.qf     = '0;
    init.qs     = '0;
    init.nf_neg = di.nf_neg;
    init.ns_neg = di.ns_neg;
    init.nf_ovf = di.nf_ovf;
    init.ns_ovf = di.ns_ovf;
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar j = 0; j < QBITS; j++) begin : g_stage
    localparam int BIT = QBITS - 1 - j;
    div_st_t          src;
    logic [DIV_W-1:0] sh;

    if (j == 0) begin : g_first
      assign src = init;
    end else begin : g_next
      assign src = st[j-1];
    end

    always_comb begin
      nxt[j] = src;
      sh = {QBITS'(0), src.dm} << BIT;
      if ({QBITS'(0), src.rf} >= sh) begin
        nxt[j].rf      = MAG_W'({QBITS'(0), src.rf} - sh);
        nxt[j].qf[BIT] = 1'b1;
      end
      if ({QBITS'(0), src.rs} >= sh) begin
        nxt[j].rs      = MAG_W'({QBITS'(0), src.rs} - sh);
        nxt[j].qs[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[j].tag.valid <= 1'b0;
      end else if (en) begin
        st[j] <= nxt[j];
      end
    end
  end

  assign dq.tag    = st[QBITS-1].tag;
  assign dq.qf     = st[QBITS-1].qf;
  assign dq.qs     = st[QBITS-1].qs;
  assign dq.nf_neg = st[QBITS-1].nf_neg;
  assign dq.ns_neg = st[QBITS-1].ns_neg;
  assign dq.nf_ovf = st[QBITS-1].nf_ovf;
  assign dq.ns_ovf = st[QBITS-1].ns_ovf;

endmodule

@@ rtl/core/quad_perspective_pixel_map.sv @@
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_stall  | first_coord, second_coord
// out      | output    | out_valid / out_stall| inside_res, source_first, source_second, map_ok
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one pixel per clock while the output is not stalled; pipeline (input register, four
// arithmetic stages, seventeen divider stages of one quotient bit each, output register).
// the divider's one-bit-per-stage chain sets the depth.
// rst clears valid bits and configuration registers to zero.
// a stalled output freezes the whole pipeline; in_stall follows out_valid && out_stall.
module quad_perspective_pixel_map import qppm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COORD_BITS-1:0]   first_coord,
  input  logic [COORD_BITS-1:0]   second_coord,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    inside_res,
  output logic signed [OUT_W-1:0] source_first,
  output logic signed [OUT_W-1:0] source_second,
  output logic                    map_ok
);

  coef_t    coef;
  corners_t corners;
  logic     en;
  logic     v0;
  logic [COORD_BITS-1:0] u0, w0;
  front_t   fo;
  div_out_t dq;

  // pipeline moves whenever the output slot is free or being taken
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef    <= '0;
      corners <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF_A:    coef[1:0]    <= cfg_data;
        REG_COEF_B:    coef[3:2]    <= cfg_data;
        REG_COEF_C:    coef[5:4]    <= cfg_data;
        REG_COEF_D:    coef[7:6]    <= cfg_data;
        REG_CORNERS_F: corners[1:0] <= cfg_data[CORNER_PAIR_W-1:0];
        REG_CORNERS_B: corners[3:2] <= cfg_data[CORNER_PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u0 <= first_coord;
      w0 <= second_coord;
    end
  end

  qppm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v0),
    .u       (u0),
    .v       (w0),
    .coef    (coef),
    .corners (corners),
    .fo      (fo)
  );

  qppm_div u_div (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .di  (fo),
    .dq  (dq)
  );

  // output register with sign and clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dq.tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_res    <= dq.tag.in_quad;
      map_ok        <= dq.tag.den_ok;
      source_first  <= dq.tag.den_ok ? sat_q(dq.qf, dq.nf_neg, dq.nf_ovf) : '0;
      source_second <= dq.tag.den_ok ? sat_q(dq.qs, dq.ns_neg, dq.ns_ovf) : '0;
    end
  end

`ifndef SYNTHESIS
  // zero denominator gives zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !map_ok |-> source_first == '0 && source_second == '0)
    else $error("zero denominator with nonzero source");

  // a valid item leaving the divider reaches the output register
  assert property (@(posedge clk) disable iff (rst)
    en && dq.tag.valid |=> out_valid)
    else $error("item lost at output register");

  // the pipeline holds while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");
`endif

endmodule
